// ===== rtl/core/mbht_pkg.sv =====
// ----------------------------------------------------------------------------
// mbht_pkg - shared constants and types for the modulo bucket hash table
//
// Table geometry, field widths, result codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mbht_pkg;

   // table geometry
   localparam int BUCKETS          = 64;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int ENTRIES          = BUCKETS * SLOTS_PER_BUCKET;

   // field widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 7;
   localparam int STAT_W  = 2;

   // derived widths
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int FILL_W   = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int ADDR_W   = $clog2(ENTRIES);
   localparam int STEP_W   = $clog2(KEY_W);
   localparam int REM_W    = CNT_W;

   // request kinds
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_GET  = 1'b1;

   // result codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DIV    = 7'b0000010,
      S_FILL   = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_CMP    = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/modulo_bucket_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// modulo_bucket_hash_table_unit - chained hash table with modulo bucket select
//
// Push appends a key/value pair to bucket (key mod bucket_count) unless it is full;
// get scans the bucket oldest first and returns the first matching value.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | word
//  --------+------------------------------+-----------------------------------
//  request | req_tvalid/tready/tdata/tuser| tdata: key, value_in; tuser: mode
//  result  | rsp_tvalid/tready/tdata/tuser| tdata: value_out; tuser: status
//  config  | csr_wen, csr_wdata           | bucket_count, 7 bits
//
//  One word at a time: the word is accepted, the remainder is formed bit-serially
//  in the subtractor, the fill count is read and the decision made, then for a
//  get the slots of the bucket are read and compared in turn (up to 8) until a
//  match or, on a miss, the end of the bucket, then the result is held until
//  taken. req_tready is low meanwhile. Reset clears the fill valid flags at
//  once; no clearing pass is needed. A stalled result holds the block; nothing
//  is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module modulo_bucket_hash_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] key, [63:32] value_in
   input  wire logic        req_tuser,   // [0] mode
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] value_out
   output logic [1:0]       rsp_tuser,   // [1:0] status
   // configuration
   input  wire logic        csr_wen,
   input  wire logic [6:0]  csr_wdata    // bucket_count
);

   // ------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------
   mbht_pkg::state_type state_ff, state_in;

   logic [mbht_pkg::CNT_W-1:0]    bcount_ff;
   logic [mbht_pkg::CNT_W-1:0]    used_n;

   logic                          mode_ff;
   logic [mbht_pkg::KEY_W-1:0]    key_ff;
   logic [mbht_pkg::VALUE_W-1:0]  val_ff;
   logic [mbht_pkg::KEY_W-1:0]    shift_ff, shift_in;
   logic [mbht_pkg::REM_W-1:0]    div_ff;
   logic [mbht_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [mbht_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [mbht_pkg::REM_W:0]      trial;
   logic [mbht_pkg::REM_W:0]      diff;

   logic [mbht_pkg::BUCKET_W-1:0] bucket;
   logic [mbht_pkg::FILL_W-1:0]   fill_cnt_ff, fill_cnt_in;
   logic [mbht_pkg::FILL_W-1:0]   scan_ff, scan_in;
   logic [mbht_pkg::FILL_W-1:0]   fill_now;

   // fill count store with per-bucket valid flags
   logic [mbht_pkg::FILL_W-1:0]   fill_mem [mbht_pkg::BUCKETS];
   logic [mbht_pkg::BUCKETS-1:0]  fill_vld_ff;
   logic [mbht_pkg::FILL_W-1:0]   fill_rd_ff;
   logic                          vld_rd_ff;
   logic                          fill_we;

   // slot stores
   logic [mbht_pkg::KEY_W-1:0]    slot_keys   [mbht_pkg::ENTRIES];
   logic [mbht_pkg::VALUE_W-1:0]  slot_values [mbht_pkg::ENTRIES];
   logic [mbht_pkg::KEY_W-1:0]    key_rd_ff;
   logic [mbht_pkg::VALUE_W-1:0]  val_rd_ff;
   logic [mbht_pkg::ADDR_W-1:0]   rd_addr;
   logic [mbht_pkg::ADDR_W-1:0]   wr_addr;
   logic                          slot_we;

   // result register
   mbht_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [mbht_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                          req_fire;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign req_tready = (state_ff == mbht_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (state_ff == mbht_pkg::S_RESP);
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // ------------------------------------------------------------------
   // bucket count register and its clamp to 1..BUCKETS
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= mbht_pkg::CNT_W'(mbht_pkg::BUCKETS);
      end else if (csr_wen) begin
         bcount_ff <= csr_wdata;
      end
   end

   always_comb begin
      used_n = bcount_ff;
      if (bcount_ff == '0) begin
         used_n = mbht_pkg::CNT_W'(1);
      end else if (bcount_ff > mbht_pkg::CNT_W'(mbht_pkg::BUCKETS)) begin
         used_n = mbht_pkg::CNT_W'(mbht_pkg::BUCKETS);
      end
   end

   // ------------------------------------------------------------------
   // shared restoring remainder step: one key bit per cycle
   // ------------------------------------------------------------------
   assign trial = {rem_ff, shift_ff[mbht_pkg::KEY_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   // remainder is below the divisor, so it fits the bucket index
   assign bucket   = rem_ff[mbht_pkg::BUCKET_W-1:0];
   assign fill_now = vld_rd_ff ? fill_rd_ff : '0;

   assign rd_addr = {bucket, scan_ff[mbht_pkg::SLOT_W-1:0]};
   assign wr_addr = {bucket, fill_now[mbht_pkg::SLOT_W-1:0]};

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      fill_cnt_in   = fill_cnt_ff;
      scan_in       = scan_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      slot_we       = 1'b0;
      fill_we       = 1'b0;

      case (state_ff)
         mbht_pkg::S_IDLE: begin
            if (req_fire) begin
               shift_in = req_tdata[31:0];
               rem_in   = '0;
               step_in  = '0;
               state_in = mbht_pkg::S_DIV;
            end
         end
         mbht_pkg::S_DIV: begin
            shift_in = {shift_ff[mbht_pkg::KEY_W-2:0], 1'b0};
            if (!diff[mbht_pkg::REM_W]) begin
               rem_in = diff[mbht_pkg::REM_W-1:0];
            end else begin
               rem_in = trial[mbht_pkg::REM_W-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == mbht_pkg::STEP_W'(mbht_pkg::KEY_W - 1)) begin
               state_in = mbht_pkg::S_FILL;
            end
         end
         mbht_pkg::S_FILL: begin
            // fill count read is in flight
            state_in = mbht_pkg::S_DECIDE;
         end
         mbht_pkg::S_DECIDE: begin
            rsp_value_in = '0;
            if (mode_ff == mbht_pkg::MODE_PUSH) begin
               if (fill_now >= mbht_pkg::FILL_W'(mbht_pkg::SLOTS_PER_BUCKET)) begin
                  rsp_status_in = mbht_pkg::ST_FULL;
               end else begin
                  slot_we       = 1'b1;
                  fill_we       = 1'b1;
                  rsp_status_in = mbht_pkg::ST_OK;
               end
               state_in = mbht_pkg::S_RESP;
            end else begin
               fill_cnt_in = fill_now;
               scan_in     = '0;
               state_in    = mbht_pkg::S_SCAN;
            end
         end
         mbht_pkg::S_SCAN: begin
            // slot read at scan_ff is in flight unless the bucket is exhausted
            if (scan_ff == fill_cnt_ff) begin
               rsp_status_in = mbht_pkg::ST_MISS;
               rsp_value_in  = '0;
               state_in      = mbht_pkg::S_RESP;
            end else begin
               state_in = mbht_pkg::S_CMP;
            end
         end
         mbht_pkg::S_CMP: begin
            if (key_rd_ff == key_ff) begin
               rsp_status_in = mbht_pkg::ST_OK;
               rsp_value_in  = val_rd_ff;
               state_in      = mbht_pkg::S_RESP;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = mbht_pkg::S_SCAN;
            end
         end
         mbht_pkg::S_RESP: begin
            if (rsp_tready) begin
               state_in = mbht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mbht_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mbht_pkg::S_IDLE;
         fill_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (fill_we) begin
            fill_vld_ff[bucket] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      fill_cnt_ff   <= fill_cnt_in;
      scan_ff       <= scan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      if (req_fire) begin
         mode_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         val_ff  <= req_tdata[63:32];
         div_ff  <= used_n;
      end
   end

   // ------------------------------------------------------------------
   // fill count memory: one write, one registered read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[bucket] <= fill_now + 1'b1;
      end
      fill_rd_ff <= fill_mem[bucket];
      vld_rd_ff  <= fill_vld_ff[bucket];
   end

   // ------------------------------------------------------------------
   // slot memories: one write, one registered read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_keys[wr_addr]   <= key_ff;
         slot_values[wr_addr] <= val_ff;
      end
      key_rd_ff <= slot_keys[rd_addr];
      val_rd_ff <= slot_values[rd_addr];
   end

endmodule

`default_nettype wire
